### rtl/kmp_pkg.sv
package kmp_pkg;

  // fixed field widths
  localparam int unsigned TEXT_W    = 8;
  localparam int unsigned STATE_W   = 5;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MATCH_W   = 32;

  // pattern storage is set by the two 64-bit registers
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned ROW_W     = PAT_BYTES + 1;
  localparam int unsigned ROW_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  typedef logic [PAT_BYTES-1:0][TEXT_W-1:0] kmp_pat_t;

  // brd[s][k]: the pattern prefix of length k-1 ends the matched text in state s
  typedef logic [PAT_BYTES-1:0][ROW_W-1:0] kmp_brd_t;

  typedef struct packed {
    kmp_pat_t         pat;
    kmp_brd_t         brd;
    logic [LEN_W-1:0] len;
  } kmp_cfg_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] start;
  } kmp_res_t;

endpackage

### rtl/kmp_cfg.sv
module kmp_cfg #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmp_pkg::CFG_W-1:0]           cfg_data,
  output kmp_pkg::kmp_cfg_t                   cfg,
  output logic                                cfg_hit
);

  logic [kmp_pkg::CFG_W-1:0] pat_lo_r, pat_lo_nxt;
  logic [kmp_pkg::CFG_W-1:0] pat_hi_r, pat_hi_nxt;
  logic [kmp_pkg::LEN_W-1:0] len_raw_r, len_raw_nxt;
  logic [kmp_pkg::LEN_W-1:0] len_r, len_nxt;
  kmp_pkg::kmp_pat_t         pat_r, pat_nxt;
  kmp_pkg::kmp_brd_t         brd_r, brd_nxt;

  // register writes, reset folds in here so the border rows follow
  always_comb begin
    pat_lo_nxt  = pat_lo_r;
    pat_hi_nxt  = pat_hi_r;
    len_raw_nxt = len_raw_r;
    cfg_hit     = 1'b0;
    if (!rst_n) begin
      pat_lo_nxt  = '0;
      pat_hi_nxt  = '0;
      len_raw_nxt = kmp_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmp_pkg::CFG_PATTERN_LOW: begin
          pat_lo_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        kmp_pkg::CFG_PATTERN_HIGH: begin
          pat_hi_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        kmp_pkg::CFG_PATTERN_LENGTH: begin
          len_raw_nxt = cfg_data[kmp_pkg::LEN_W-1:0];
          cfg_hit     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    len_nxt = len_raw_nxt;
    if (len_raw_nxt == '0) begin
      len_nxt = kmp_pkg::LEN_W'(1);
    end else if (len_raw_nxt > kmp_pkg::LEN_W'(MAX_PATTERN)) begin
      len_nxt = kmp_pkg::LEN_W'(MAX_PATTERN);
    end
  end

  assign pat_nxt = {pat_hi_nxt, pat_lo_nxt};

  // border rows: prefix of length k-1 equals the k-1 bytes ending at s-1
  always_comb begin
    logic ok;
    brd_nxt = '0;
    for (int s = 0; s < MAX_PATTERN; s++) begin
      for (int k = 1; k <= s + 1; k++) begin
        ok = 1'b1;
        for (int i = 0; i < k - 1; i++) begin
          if (pat_nxt[i] != pat_nxt[s-k+1+i]) begin
            ok = 1'b0;
          end
        end
        brd_nxt[s][k] = ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_lo_r  <= pat_lo_nxt;
    pat_hi_r  <= pat_hi_nxt;
    len_raw_r <= len_raw_nxt;
    len_r     <= len_nxt;
    pat_r     <= pat_nxt;
    brd_r     <= brd_nxt;
  end

  assign cfg.pat = pat_r;
  assign cfg.brd = brd_r;
  assign cfg.len = len_r;

endmodule

### rtl/kmp_step.sv
module kmp_step #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [kmp_pkg::TEXT_W-1:0]    text_byte,
  input  logic                          start_of_text,
  input  kmp_pkg::kmp_cfg_t             cfg,
  input  logic                          cfg_hit,
  output kmp_pkg::kmp_res_t             res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [kmp_pkg::STATE_W-1:0] state_r, state_nxt;
  logic [POSITION_BITS-1:0]    pos_r, pos_nxt;
  logic [kmp_pkg::STATE_W-1:0] s_cur;
  logic [POSITION_BITS-1:0]    pos_cur;
  logic [kmp_pkg::STATE_W-1:0] s_adv;
  logic                        byte_ok;
  logic                        found;
  logic [POSITION_BITS-1:0]    start;

  assign s_cur   = start_of_text ? '0 : state_r;
  assign pos_cur = start_of_text ? '0 : pos_r;
  assign byte_ok = ({1'b0, text_byte} < (kmp_pkg::TEXT_W + 1)'(ALPHABET_SIZE));

  // longest prefix that ends the text: highest k whose border holds and whose
  // last pattern byte is this byte
  always_comb begin
    s_adv = '0;
    if (byte_ok) begin
      for (int k = 1; k <= MAX_PATTERN; k++) begin
        if (cfg.brd[s_cur[kmp_pkg::ROW_IDX_W-1:0]][k] && (cfg.pat[k-1] == text_byte)) begin
          s_adv = kmp_pkg::STATE_W'(k);
        end
      end
    end
  end

  assign found = (s_adv >= cfg.len);
  assign start = pos_cur - POSITION_BITS'(cfg.len) + POSITION_BITS'(1);

  assign res.found = found;
  assign res.start = found ? kmp_pkg::MATCH_W'(start) : '0;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (!rst_n) begin
      state_nxt = '0;
      pos_nxt   = '0;
    end else if (cfg_hit) begin
      state_nxt = '0;
    end else if (accept) begin
      state_nxt = found ? '0 : s_adv;
      pos_nxt   = (pos_cur != POS_MAX) ? pos_cur + POSITION_BITS'(1) : pos_cur;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    pos_r   <= pos_nxt;
  end

endmodule

### rtl/kmp_obuf.sv
module kmp_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kmp_pkg::kmp_res_t   push_res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output kmp_pkg::kmp_res_t   out_res
);

  logic              main_vld_r, main_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  kmp_pkg::kmp_res_t main_r, main_nxt;
  kmp_pkg::kmp_res_t skid_r, skid_nxt;
  logic              take;

  assign take = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // no push while the skid holds a beat
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || take) begin
        main_nxt     = push_res;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_res;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule

### rtl/kmp_dfa_substring_matcher_top.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------------------
// in       | in_valid  | in_stall  | in_text_byte, in_start_of_text
// out      | out_valid | out_stall | out_match_found, out_match_start
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// one text beat per cycle while in_stall is low; its result enters the output buffer the next cycle
// one automaton step sets the rate: border rows are precomputed at each
// register write, so a byte needs one compare per pattern byte and a priority pick
// reset is synchronous; border rows are ready the cycle after any write
// two output entries let input run on while one result waits; in_stall
// rises only when both entries hold results

module kmp_dfa_substring_matcher_top #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // text beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kmp_pkg::TEXT_W-1:0]      in_text_byte,
  input  logic                            in_start_of_text,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_match_found,
  output logic [kmp_pkg::MATCH_W-1:0]     out_match_start,
  // register writes
  input  logic                            cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmp_pkg::CFG_W-1:0]       cfg_data
);

  kmp_pkg::kmp_cfg_t cfg;
  logic              cfg_hit;
  logic              accept;
  kmp_pkg::kmp_res_t step_res;
  kmp_pkg::kmp_res_t out_res;

  // text beat taken this cycle
  assign accept = in_valid && !in_stall;

  // pattern registers and the precomputed border rows of the automaton
  kmp_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_hit   (cfg_hit)
  );

  // match state and text position, one automaton move per beat
  kmp_step #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .text_byte     (in_text_byte),
    .start_of_text (in_start_of_text),
    .cfg           (cfg),
    .cfg_hit       (cfg_hit),
    .res           (step_res)
  );

  // result register plus skid entry
  kmp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (step_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_match_found = out_res.found;
  assign out_match_start = out_res.start;

endmodule

### rtl/kmp_chk.sv
module kmp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_match_found,
  input logic [kmp_pkg::MATCH_W-1:0]   out_match_start
);

  // input only backs up when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a beat without a match carries a zero offset
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_match_found) |-> (out_match_start == '0))
    else $error("nonzero match_start without a match");

  // an accepted input beat always yields a result beat the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_match_found)
                                  && $stable(out_match_start)))
    else $error("stalled result changed");

endmodule

bind kmp_dfa_substring_matcher_top kmp_chk u_kmp_chk (.*);
